### hw/rtl/cbpm_pkg.sv
package cbpm_pkg;

    localparam int FRAMES_DEF       = 16;
    localparam int PAGE_ID_BITS_DEF = 32;
    localparam int PIN_BITS_DEF     = 8;

    localparam logic [1:0] REQ_FETCH   = 2'd0;
    localparam logic [1:0] REQ_UNPIN   = 2'd1;
    localparam logic [1:0] REQ_FLUSH   = 2'd2;
    localparam logic [1:0] REQ_INSTALL = 2'd3;

    localparam logic [1:0] STAT_HIT    = 2'd0;
    localparam logic [1:0] STAT_MISS   = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;
    localparam logic [1:0] STAT_PINNED = 2'd3;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_READ = 2'd1;
    localparam logic [1:0] FILL_INIT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SW_RD,
        ST_SW_CHK,
        ST_OUT
    } state_t;

endpackage

### hw/rtl/clock_buffer_pool_manager_core.sv
// channel  | direction | tdata (lsb up)                                  | tuser (lsb up)
// s_axis   | in        | page_id                                         | req_type, mark_dirty
// m_axis   | out       | frame_index, fill_kind, writeback,              | status
//          |           | writeback_page, result_page                     |
// Every item first scans all FRAMES frame records, one per cycle from the
// record memory, before a hit or a refused request is answered.
// A miss then runs the clock sweep, a read (ST_SW_RD) and then a check (ST_SW_CHK)
// per frame visited through the single read port, at most 2 * FRAMES visits.
// Reset marks all frames empty and sets the hand to zero; no clearing pass.
// A result waits in the output register while the next item is taken.
module clock_buffer_pool_manager_core
    import cbpm_pkg::*;
#(
    parameter int FRAMES       = FRAMES_DEF,
    parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF,
    parameter int PIN_BITS     = PIN_BITS_DEF,
    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int IN_W    = ((PAGE_ID_BITS + 7) / 8) * 8,
    localparam int OUT_RAW = IDX_W + 3 + 2 * PAGE_ID_BITS,
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // page_id
    input  logic [2:0]       s_axis_tuser,  // req_type, mark_dirty
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // frame_index, fill_kind, writeback,
                                            // writeback_page, result_page
    output logic [1:0]       m_axis_tuser   // status
);

    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int REC_W = PAGE_ID_BITS + 2 + PIN_BITS;
    localparam int REF_B = PIN_BITS;
    localparam int DRT_B = PIN_BITS + 1;
    localparam int TAG_L = PIN_BITS + 2;

    state_t state_reg, state_next;

    logic [1:0]              req_reg, req_next;
    logic [PAGE_ID_BITS-1:0] id_reg, id_next;
    logic                    mark_reg, mark_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic [REC_W-1:0]        hit_rec_reg, hit_rec_next;
    logic                    free_reg, free_next;
    logic [IDX_W-1:0]        hand_reg, hand_next;
    logic [FRAMES-1:0]       valid_reg, valid_next;

    logic [1:0]              res_status_reg, res_status_next;
    logic [IDX_W-1:0]        res_frame_reg, res_frame_next;
    logic [1:0]              res_fill_reg, res_fill_next;
    logic                    res_wb_reg, res_wb_next;
    logic [PAGE_ID_BITS-1:0] res_wbp_reg, res_wbp_next;

    logic                    out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]        out_tdata_reg, out_tdata_next;
    logic [1:0]              out_tuser_reg, out_tuser_next;

    logic [REC_W-1:0]        rec_mem [FRAMES];
    logic [REC_W-1:0]        rd_data_reg;
    logic [IDX_W-1:0]        mem_raddr;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [REC_W-1:0]        mem_wdata;

    logic                    in_fire;
    logic                    out_load;
    logic [IDX_W-1:0]        chk_idx;
    logic [REC_W-1:0]        scan_rec;
    logic [REC_W-1:0]        hand_rec;
    logic [REC_W-1:0]        upd_rec;
    logic [PIN_BITS-1:0]     hit_pins;
    logic [IDX_W-1:0]        hand_inc;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign chk_idx   = IDX_W'(cnt_reg - CNT_W'(1));
    assign scan_rec  = valid_reg[chk_idx] ? rd_data_reg : '0;
    assign hand_rec  = valid_reg[hand_reg] ? rd_data_reg : '0;
    assign hit_pins  = hit_rec_reg[PIN_BITS-1:0];
    assign hand_inc  = (hand_reg == IDX_W'(FRAMES - 1)) ? '0 : hand_reg + IDX_W'(1);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;
    assign m_axis_tuser  = out_tuser_reg;

    always_comb
    begin
        if (state_reg == ST_SW_RD)
        begin
            mem_raddr = hand_reg;
        end
        else if (cnt_reg < CNT_W'(FRAMES))
        begin
            mem_raddr = cnt_reg[IDX_W-1:0];
        end
        else
        begin
            mem_raddr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= rec_mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(FRAMES))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (hit_reg || req_reg == REQ_UNPIN || req_reg == REQ_FLUSH || !free_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SW_RD;
                end
            end
            ST_SW_RD:
            begin
                state_next = ST_SW_CHK;
            end
            ST_SW_CHK:
            begin
                if (hand_rec[PIN_BITS-1:0] != '0 || hand_rec[REF_B])
                begin
                    state_next = ST_SW_RD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next        = req_reg;
        id_next         = id_reg;
        mark_next       = mark_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rec_next    = hit_rec_reg;
        free_next       = free_reg;
        hand_next       = hand_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_frame_next  = res_frame_reg;
        res_fill_next   = res_fill_reg;
        res_wb_next     = res_wb_reg;
        res_wbp_next    = res_wbp_reg;
        out_valid_next  = out_valid_reg;
        out_tdata_next  = out_tdata_reg;
        out_tuser_next  = out_tuser_reg;
        mem_we          = 1'b0;
        mem_waddr       = hand_reg;
        mem_wdata       = '0;
        upd_rec         = hit_rec_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    req_next  = s_axis_tuser[1:0];
                    mark_next = s_axis_tuser[2];
                    id_next   = s_axis_tdata[PAGE_ID_BITS-1:0];
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg != '0)
                begin
                    if (valid_reg[chk_idx] && !hit_reg
                        && rd_data_reg[REC_W-1:TAG_L] == id_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = chk_idx;
                        hit_rec_next = rd_data_reg;
                    end
                    if (scan_rec[PIN_BITS-1:0] == '0)
                    begin
                        free_next = 1'b1;
                    end
                end
            end
            ST_DECIDE:
            begin
                res_frame_next  = '0;
                res_fill_next   = FILL_NONE;
                res_wb_next     = 1'b0;
                res_wbp_next    = '0;
                if (hit_reg)
                begin
                    res_status_next = STAT_HIT;
                    res_frame_next  = hit_idx_reg;
                    unique case (req_reg)
                        REQ_UNPIN:
                        begin
                            if (hit_pins != '0)
                            begin
                                upd_rec[PIN_BITS-1:0] = hit_pins - PIN_BITS'(1);
                            end
                            if (mark_reg)
                            begin
                                upd_rec[DRT_B] = 1'b1;
                            end
                        end
                        REQ_FLUSH:
                        begin
                            upd_rec[DRT_B] = 1'b0;
                            res_wb_next    = 1'b1;
                            res_wbp_next   = id_reg;
                        end
                        REQ_FETCH, REQ_INSTALL:
                        begin
                            upd_rec[REF_B] = 1'b1;
                            if (hit_pins != '1)
                            begin
                                upd_rec[PIN_BITS-1:0] = hit_pins + PIN_BITS'(1);
                            end
                            if (req_reg == REQ_INSTALL)
                            begin
                                upd_rec[DRT_B] = 1'b0;
                                res_fill_next  = FILL_INIT;
                            end
                        end
                        default:
                        begin
                            upd_rec = hit_rec_reg;
                        end
                    endcase
                    mem_we    = 1'b1;
                    mem_waddr = hit_idx_reg;
                    mem_wdata = upd_rec;
                end
                else if (req_reg == REQ_UNPIN || req_reg == REQ_FLUSH)
                begin
                    res_status_next = STAT_ABSENT;
                end
                else if (!free_reg)
                begin
                    res_status_next = STAT_PINNED;
                end
            end
            ST_SW_RD:
            begin
                res_status_next = STAT_MISS;
            end
            ST_SW_CHK:
            begin
                hand_next = hand_inc;
                if (hand_rec[PIN_BITS-1:0] != '0)
                begin
                    mem_we = 1'b0;
                end
                else if (hand_rec[REF_B])
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = hand_reg;
                    mem_wdata      = hand_rec;
                    mem_wdata[REF_B] = 1'b0;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = hand_reg;
                    mem_wdata  = {id_reg, 1'b0, 1'b1, PIN_BITS'(1)};
                    valid_next[hand_reg] = 1'b1;
                    res_frame_next = hand_reg;
                    res_fill_next  = (req_reg == REQ_INSTALL) ? FILL_INIT : FILL_READ;
                    res_wb_next    = valid_reg[hand_reg] && hand_rec[DRT_B];
                    res_wbp_next   = (valid_reg[hand_reg] && hand_rec[DRT_B])
                                     ? hand_rec[REC_W-1:TAG_L] : '0;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_tuser_next = res_status_reg;
                    out_tdata_next = OUT_W'({id_reg, res_wbp_reg, res_wb_reg,
                                             res_fill_reg, res_frame_reg});
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hand_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hand_reg      <= hand_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        id_reg         <= id_next;
        mark_reg       <= mark_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rec_reg    <= hit_rec_next;
        res_status_reg <= res_status_next;
        res_frame_reg  <= res_frame_next;
        res_fill_reg   <= res_fill_next;
        res_wb_reg     <= res_wb_next;
        res_wbp_reg    <= res_wbp_next;
        out_tdata_reg  <= out_tdata_next;
        out_tuser_reg  <= out_tuser_next;
    end

endmodule

### hw/rtl/cbpm_checker.sv
module cbpm_checker
    import cbpm_pkg::*;
#(
    parameter int FRAMES       = FRAMES_DEF,
    parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF,
    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int IN_W    = ((PAGE_ID_BITS + 7) / 8) * 8,
    localparam int OUT_RAW = IDX_W + 3 + 2 * PAGE_ID_BITS,
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,  // page_id
    input logic [2:0]       s_axis_tuser,  // req_type, mark_dirty
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,  // frame_index, fill_kind, writeback,
                                           // writeback_page, result_page
    input logic [1:0]       m_axis_tuser   // status
);

    logic [IDX_W-1:0]        frame;
    logic [1:0]              fill;
    logic                    wb;
    logic [PAGE_ID_BITS-1:0] wbp;

    assign frame = m_axis_tdata[IDX_W-1:0];
    assign fill  = m_axis_tdata[IDX_W+1:IDX_W];
    assign wb    = m_axis_tdata[IDX_W+2];
    assign wbp   = m_axis_tdata[IDX_W+3 +: PAGE_ID_BITS];

    // busy while an item is at work
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata == s_axis_tdata)
        |=> !s_axis_tready)
        else $error("input ready right after accept");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_refused_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == STAT_ABSENT || m_axis_tuser == STAT_PINNED))
        |-> (frame == '0 && fill == FILL_NONE && !wb))
        else $error("refused request carries a frame");

    a_wb_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !wb) |-> (wbp == '0))
        else $error("write-back page without write back");

    a_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == STAT_MISS)
        |-> (fill == FILL_READ || fill == FILL_INIT))
        else $error("miss without fill");

endmodule

bind clock_buffer_pool_manager_core cbpm_checker #(
    .FRAMES(FRAMES),
    .PAGE_ID_BITS(PAGE_ID_BITS)
) u_cbpm_checker (.*);
